### hw/rtl/io_expander_register_map_top_macros.svh
// Assertion macros for the checker file.
`ifndef IO_EXPANDER_REGISTER_MAP_TOP_MACROS_SVH
`define IO_EXPANDER_REGISTER_MAP_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define IOX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("io expander check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define IOX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("io expander check failed");

`endif

### hw/rtl/io_exp_pkg.sv
package io_exp_pkg;

    // Default sizes
    localparam int MAP_BYTES_DEF       = 160;
    localparam int BURST_BYTES_DEF     = 32;
    localparam int ANALOG_CHANNELS_DEF = 4;
    localparam int DIGITAL_INPUTS_DEF  = 3;
    localparam int COUNTED_INPUTS_DEF  = 2;

    // Command queue depth, kept a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;

    // Channels carried on the input ports
    localparam int FIELD_ANALOG = 4;

    // Bus modes
    localparam logic [2:0] MODE_ADDR   = 3'd0;
    localparam logic [2:0] MODE_DATA   = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_SAMPLE = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    // Map layout
    localparam logic [7:0] ADDR_ID      = 8'h00;
    localparam logic [7:0] ADDR_HW      = 8'h01;
    localparam logic [7:0] ADDR_FW      = 8'h02;
    localparam logic [7:0] ADDR_POLL    = 8'h05;
    localparam logic [7:0] ADDR_DEBOUNCE = 8'h06;
    localparam logic [7:0] ADDR_GATE    = 8'h08;
    localparam logic [7:0] ADDR_EDGE    = 8'h09;
    localparam logic [7:0] BASE_ANALOG  = 8'h20;
    localparam logic [7:0] BASE_DIGITAL = 8'h50;
    localparam logic [7:0] BASE_COUNT   = 8'h60;

    // Reset values of the settings bytes
    localparam logic [7:0] RST_ID   = 8'h85;
    localparam logic [7:0] RST_VER  = 8'd1;
    localparam logic [7:0] RST_POLL = 8'd50;
    localparam logic [7:0] RST_GATE = 8'd5;
    localparam logic [7:0] RST_EDGE = 8'd3;

    // Gate ticks per second of gate length
    localparam logic [9:0] GATE_SCALE = 10'd1000;

    // Edge mode codes
    localparam logic [7:0] EDGE_ANY  = 8'd1;
    localparam logic [7:0] EDGE_FALL = 8'd2;
    localparam logic [7:0] EDGE_RISE = 8'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_SAMPLE,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      addr;
        logic [7:0]      data;
        logic [2:0]      levels;
        logic [3:0][9:0] analog;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_POLL,
        BK_GATE
    } bk_state_t;

    // Value a map byte holds before its first write
    function automatic logic [7:0] reset_byte(input logic [7:0] a);
        logic [7:0] v;
        case (a)
            ADDR_ID:       v = RST_ID;
            ADDR_HW:       v = RST_VER;
            ADDR_FW:       v = RST_VER;
            ADDR_POLL:     v = RST_POLL;
            ADDR_DEBOUNCE: v = RST_POLL;
            ADDR_GATE:     v = RST_GATE;
            ADDR_EDGE:     v = RST_EDGE;
            default:       v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/io_exp_ram.sv
module io_exp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/io_exp_front.sv
module io_exp_front #(
    parameter int MAP_BYTES = io_exp_pkg::MAP_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              full,
    input  logic [2:0]        mode,
    input  logic [7:0]        bus_byte,
    input  logic [2:0]        digital_levels,
    input  logic [9:0]        analog_zero,
    input  logic [9:0]        analog_one,
    input  logic [9:0]        analog_two,
    input  logic [9:0]        analog_three,
    output logic              push,
    output io_exp_pkg::cmd_t  cmd
);
    import io_exp_pkg::*;

    localparam logic [8:0] MAP_END = 9'(MAP_BYTES);

    logic       accept;
    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] woff_reg, woff_next;
    logic       wact_reg, wact_next;

    assign accept = start && !full;

    // Classify the beat and track the write transaction
    always_comb
    begin
        ptr_next   = ptr_reg;
        woff_next  = woff_reg;
        wact_next  = wact_reg;
        push       = 1'b0;
        cmd.op     = OP_WRITE;
        cmd.addr   = woff_reg;
        cmd.data   = bus_byte;
        cmd.levels = digital_levels;
        cmd.analog = {analog_three, analog_two, analog_one, analog_zero};
        if (accept)
        begin
            case (mode)
                MODE_ADDR:
                begin
                    if ({1'b0, bus_byte} < MAP_END)
                    begin
                        ptr_next  = bus_byte;
                        woff_next = bus_byte;
                        wact_next = 1'b1;
                    end
                    else
                    begin
                        wact_next = 1'b0;
                    end
                end
                MODE_DATA:
                begin
                    if (wact_reg && ({1'b0, woff_reg} < MAP_END))
                    begin
                        push = 1'b1;
                        if ({1'b0, woff_reg} + 9'd1 >= MAP_END)
                        begin
                            wact_next = 1'b0;
                        end
                        else
                        begin
                            woff_next = woff_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        wact_next = 1'b0;
                    end
                end
                MODE_READ:
                begin
                    wact_next = 1'b0;
                    push      = 1'b1;
                    cmd.op    = OP_READ;
                    cmd.addr  = ({1'b0, ptr_reg} >= MAP_END) ? 8'd0 : ptr_reg;
                end
                MODE_SAMPLE:
                begin
                    push   = 1'b1;
                    cmd.op = OP_SAMPLE;
                end
                MODE_TICK:
                begin
                    push   = 1'b1;
                    cmd.op = OP_TICK;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= 8'd0;
            woff_reg <= 8'd0;
            wact_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            woff_reg <= woff_next;
            wact_reg <= wact_next;
        end
    end

endmodule

### hw/rtl/io_exp_queue.sv
module io_exp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  io_exp_pkg::cmd_t  push_cmd,
    input  logic              pop,
    output io_exp_pkg::cmd_t  head,
    output logic              avail,
    output logic              full
);
    import io_exp_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    cmd_t          ent_reg [QUEUE_DEPTH];
    logic [QW-1:0] wptr_reg, rptr_reg;
    logic [QW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == (QW+1)'(QUEUE_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign head    = ent_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Hold command payloads
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/io_exp_back.sv
module io_exp_back #(
    parameter int MAP_BYTES       = io_exp_pkg::MAP_BYTES_DEF,
    parameter int BURST_BYTES     = io_exp_pkg::BURST_BYTES_DEF,
    parameter int ANALOG_CHANNELS = io_exp_pkg::ANALOG_CHANNELS_DEF,
    parameter int DIGITAL_INPUTS  = io_exp_pkg::DIGITAL_INPUTS_DEF,
    parameter int COUNTED_INPUTS  = io_exp_pkg::COUNTED_INPUTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  io_exp_pkg::cmd_t             head,
    input  logic                         avail,
    output logic                         pop,
    output logic                         mem_we,
    output logic [$clog2(MAP_BYTES)-1:0] mem_waddr,
    output logic [7:0]                   mem_wdata,
    output logic                         mem_ren,
    output logic [$clog2(MAP_BYTES)-1:0] mem_raddr,
    input  logic [7:0]                   mem_rdata,
    output logic                         strobe,
    output logic [7:0]                   read_data,
    output logic [7:0]                   read_address,
    output logic                         burst_last
);
    import io_exp_pkg::*;

    localparam int         AW      = $clog2(MAP_BYTES);
    localparam int         NPOLL   = 2 * ANALOG_CHANNELS + DIGITAL_INPUTS;
    localparam int         NGATE   = 4 * COUNTED_INPUTS;
    localparam int         NSEQ    = (NPOLL > NGATE) ? NPOLL : NGATE;
    localparam int         SW      = $clog2(NSEQ + 1);
    localparam int         CW      = $clog2(BURST_BYTES + 1);
    localparam logic [8:0] MAP_END = 9'(MAP_BYTES);

    bk_state_t state_reg, state_next;

    logic [COUNTED_INPUTS-1:0] prev_reg;
    logic [31:0]               cnt_reg [COUNTED_INPUTS];
    logic [8:0]                poll_reg;
    logic [17:0]               gate_reg;
    logic [7:0]                poll_byte_reg, gate_byte_reg, edge_byte_reg;
    logic [SW-1:0]             seq_reg;
    logic                      gate_pend_reg;
    logic [2:0]                tick_lv_reg;
    logic [3:0][9:0]           tick_an_reg;
    logic [8:0]                rd_addr_reg;
    logic [CW-1:0]             rd_left_reg;
    logic                      out_vld_reg, out_last_reg, out_hit_reg;
    logic [7:0]                out_addr_reg;
    logic [MAP_BYTES-1:0]      vld_reg;

    // Decoded per-cycle controls
    logic          is_write, is_read, is_sample, is_tick;
    logic          poll_hit, gate_hit;
    logic [17:0]   gate_len;
    logic [8:0]    wr_addr;
    logic [7:0]    wr_data;
    logic          wr_req, wr_en;
    logic          seq_end;
    logic [9:0]    rd_rem;
    logic [CW-1:0] rd_cnt;
    logic          rd_last;

    // Byte sources for the poll and gate sweeps
    logic [SW-1:0]                 poll_ch, poll_dig, gate_idx;
    logic [9:0]                    an_sel;
    logic [31:0]                   cnt_sel;
    logic [9:0]                    an_ext [ANALOG_CHANNELS + FIELD_ANALOG];
    logic [DIGITAL_INPUTS+2:0]     dig_ext;
    logic                          dig_sel;
    logic [COUNTED_INPUTS+2:0]     lv_ext;
    logic [31:0]                   cnt_next [COUNTED_INPUTS];
    logic [COUNTED_INPUTS-1:0]     prev_next;

    assign is_write  = avail && (head.op == OP_WRITE);
    assign is_read   = avail && (head.op == OP_READ);
    assign is_sample = avail && (head.op == OP_SAMPLE);
    assign is_tick   = avail && (head.op == OP_TICK);

    assign gate_len = 18'(gate_byte_reg) * 18'(GATE_SCALE);
    assign poll_hit = (10'(poll_reg) + 10'd1) > {2'd0, poll_byte_reg};
    assign gate_hit = (19'(gate_reg) + 19'd1) >= {1'b0, gate_len};

    assign rd_rem  = 10'(MAP_END) - {2'd0, head.addr};
    assign rd_cnt  = (rd_rem < 10'(BURST_BYTES)) ? CW'(rd_rem) : CW'(BURST_BYTES);
    assign rd_last = (rd_left_reg == CW'(1));

    assign seq_end = (state_reg == BK_POLL) ? (seq_reg == SW'(NPOLL - 1))
                                            : (seq_reg == SW'(NGATE - 1));

    // Select the sweep byte sources
    always_comb
    begin
        poll_ch  = seq_reg >> 1;
        poll_dig = seq_reg - SW'(2 * ANALOG_CHANNELS);
        gate_idx = seq_reg >> 2;
        for (int k = 0; k < ANALOG_CHANNELS + FIELD_ANALOG; k++)
        begin
            an_ext[k] = (k < FIELD_ANALOG) ? tick_an_reg[2'(k)] : 10'd0;
        end
        dig_ext = (DIGITAL_INPUTS+3)'(tick_lv_reg);
        an_sel  = 10'd0;
        for (int k = 0; k < ANALOG_CHANNELS; k++)
        begin
            if (poll_ch == SW'(k))
            begin
                an_sel = an_ext[k];
            end
        end
        dig_sel = 1'b0;
        for (int k = 0; k < DIGITAL_INPUTS; k++)
        begin
            if (poll_dig == SW'(k))
            begin
                dig_sel = dig_ext[k];
            end
        end
        cnt_sel = 32'd0;
        for (int k = 0; k < COUNTED_INPUTS; k++)
        begin
            if (gate_idx == SW'(k))
            begin
                cnt_sel = cnt_reg[k];
            end
        end
    end

    // Count edges for a sample beat
    always_comb
    begin
        lv_ext = (COUNTED_INPUTS+3)'(head.levels);
        for (int k = 0; k < COUNTED_INPUTS; k++)
        begin
            cnt_next[k]  = cnt_reg[k];
            prev_next[k] = lv_ext[k];
            case (edge_byte_reg)
                EDGE_ANY:
                begin
                    if (lv_ext[k] != prev_reg[k])
                    begin
                        cnt_next[k] = cnt_reg[k] + 32'd1;
                    end
                end
                EDGE_FALL:
                begin
                    if (!lv_ext[k] && prev_reg[k])
                    begin
                        cnt_next[k] = cnt_reg[k] + 32'd1;
                    end
                end
                EDGE_RISE:
                begin
                    if (lv_ext[k] && !prev_reg[k])
                    begin
                        cnt_next[k] = cnt_reg[k] + 32'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (is_read)
                begin
                    state_next = BK_READ;
                end
                else if (is_tick && poll_hit)
                begin
                    state_next = BK_POLL;
                end
                else if (is_tick && gate_hit)
                begin
                    state_next = BK_GATE;
                end
            end
            BK_READ:
            begin
                if (rd_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_POLL:
            begin
                if (seq_end)
                begin
                    state_next = gate_pend_reg ? BK_GATE : BK_IDLE;
                end
            end
            BK_GATE:
            begin
                if (seq_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, map write and read port
    always_comb
    begin
        pop     = 1'b0;
        wr_req  = 1'b0;
        wr_addr = {1'b0, head.addr};
        wr_data = head.data;
        mem_ren = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop    = avail;
                wr_req = is_write;
            end
            BK_READ:
            begin
                mem_ren = 1'b1;
            end
            BK_POLL:
            begin
                wr_req = 1'b1;
                if (seq_reg < SW'(2 * ANALOG_CHANNELS))
                begin
                    wr_addr = {1'b0, BASE_ANALOG} + 9'(seq_reg);
                    wr_data = seq_reg[0] ? an_sel[7:0] : {6'd0, an_sel[9:8]};
                end
                else
                begin
                    wr_addr = {1'b0, BASE_DIGITAL} + 9'(poll_dig);
                    wr_data = {7'd0, dig_sel};
                end
            end
            BK_GATE:
            begin
                wr_req  = 1'b1;
                wr_addr = {1'b0, BASE_COUNT} + 9'(seq_reg);
                case (seq_reg[1:0])
                    2'd0:    wr_data = cnt_sel[31:24];
                    2'd1:    wr_data = cnt_sel[23:16];
                    2'd2:    wr_data = cnt_sel[15:8];
                    default: wr_data = cnt_sel[7:0];
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign wr_en     = wr_req && (wr_addr < MAP_END);
    assign mem_we    = wr_en;
    assign mem_waddr = AW'(wr_addr);
    assign mem_wdata = wr_data;
    assign mem_raddr = AW'(rd_addr_reg);

    // Drop a result beat in the cycle after its map read
    assign strobe       = out_vld_reg;
    assign read_address = out_addr_reg;
    assign burst_last   = out_last_reg;
    assign read_data    = out_hit_reg ? mem_rdata : reset_byte(out_addr_reg);

    // Hold result and sweep payloads
    always_ff @(posedge clk)
    begin
        out_addr_reg <= 8'(rd_addr_reg);
        out_last_reg <= rd_last;
        out_hit_reg  <= vld_reg[AW'(rd_addr_reg)];
        if (state_reg == BK_IDLE && is_tick)
        begin
            tick_lv_reg <= head.levels;
            tick_an_reg <= head.analog;
        end
    end

    // Advance the sequencer and the counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            prev_reg      <= '0;
            for (int k = 0; k < COUNTED_INPUTS; k++)
            begin
                cnt_reg[k] <= 32'd0;
            end
            poll_reg      <= 9'd0;
            gate_reg      <= 18'd0;
            poll_byte_reg <= RST_POLL;
            gate_byte_reg <= RST_GATE;
            edge_byte_reg <= RST_EDGE;
            seq_reg       <= '0;
            gate_pend_reg <= 1'b0;
            rd_addr_reg   <= 9'd0;
            rd_left_reg   <= '0;
            out_vld_reg   <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= (state_reg == BK_READ);
            if (wr_en)
            begin
                vld_reg[AW'(wr_addr)] <= 1'b1;
                if (wr_addr == {1'b0, ADDR_POLL})
                begin
                    poll_byte_reg <= wr_data;
                end
                if (wr_addr == {1'b0, ADDR_GATE})
                begin
                    gate_byte_reg <= wr_data;
                end
                if (wr_addr == {1'b0, ADDR_EDGE})
                begin
                    edge_byte_reg <= wr_data;
                end
            end
            case (state_reg)
                BK_IDLE:
                begin
                    if (is_read)
                    begin
                        rd_addr_reg <= {1'b0, head.addr};
                        rd_left_reg <= rd_cnt;
                    end
                    if (is_sample)
                    begin
                        prev_reg <= prev_next;
                        for (int k = 0; k < COUNTED_INPUTS; k++)
                        begin
                            cnt_reg[k] <= cnt_next[k];
                        end
                    end
                    if (is_tick)
                    begin
                        poll_reg      <= poll_hit ? 9'd0 : poll_reg + 9'd1;
                        gate_reg      <= gate_hit ? 18'd0 : gate_reg + 18'd1;
                        gate_pend_reg <= gate_hit;
                        seq_reg       <= '0;
                    end
                end
                BK_READ:
                begin
                    rd_addr_reg <= rd_addr_reg + 9'd1;
                    rd_left_reg <= rd_left_reg - CW'(1);
                end
                BK_POLL:
                begin
                    seq_reg <= seq_end ? '0 : seq_reg + SW'(1);
                end
                BK_GATE:
                begin
                    seq_reg <= seq_end ? '0 : seq_reg + SW'(1);
                    if (seq_end)
                    begin
                        for (int k = 0; k < COUNTED_INPUTS; k++)
                        begin
                            cnt_reg[k] <= 32'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/io_expander_register_map_top.sv
// Channel    | Handshake         | Payload
// command in | start / busy      | mode, bus_byte, digital_levels, analog_zero..analog_three
// result out | strobe (1 cycle)  | read_data, read_address, burst_last
//
// A command is taken when start is high and busy low; it waits in a two-entry queue.
// Back end: data and sample beats are handled in the idle state (address beats stay
// in the front end); a read streams n bytes, one per cycle through the map RAM's read
// port, each result in the cycle after its read; a tick may then write one map byte
// per cycle, 2*ANALOG_CHANNELS+DIGITAL_INPUTS on a poll and 4*COUNTED_INPUTS on a gate.
// Reset is immediate: per-byte valid bits make unwritten bytes read their defaults.
// busy is high only while the queue is full; results cannot be stalled.
module io_expander_register_map_top #(
    parameter int MAP_BYTES       = io_exp_pkg::MAP_BYTES_DEF,
    parameter int BURST_BYTES     = io_exp_pkg::BURST_BYTES_DEF,
    parameter int ANALOG_CHANNELS = io_exp_pkg::ANALOG_CHANNELS_DEF,
    parameter int DIGITAL_INPUTS  = io_exp_pkg::DIGITAL_INPUTS_DEF,
    parameter int COUNTED_INPUTS  = io_exp_pkg::COUNTED_INPUTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] mode,
    input  logic [7:0] bus_byte,
    input  logic [2:0] digital_levels,
    input  logic [9:0] analog_zero,
    input  logic [9:0] analog_one,
    input  logic [9:0] analog_two,
    input  logic [9:0] analog_three,
    output logic       strobe,
    output logic [7:0] read_data,
    output logic [7:0] read_address,
    output logic       burst_last
);
    import io_exp_pkg::*;

    localparam int AW = $clog2(MAP_BYTES);

    cmd_t          push_cmd, head;
    logic          push, pop, avail, full;
    logic          mem_we, mem_ren;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    assign busy = full;

    io_exp_front #(
        .MAP_BYTES(MAP_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .full          (full),
        .mode          (mode),
        .bus_byte      (bus_byte),
        .digital_levels(digital_levels),
        .analog_zero   (analog_zero),
        .analog_one    (analog_one),
        .analog_two    (analog_two),
        .analog_three  (analog_three),
        .push          (push),
        .cmd           (push_cmd)
    );

    io_exp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .avail   (avail),
        .full    (full)
    );

    io_exp_back #(
        .MAP_BYTES      (MAP_BYTES),
        .BURST_BYTES    (BURST_BYTES),
        .ANALOG_CHANNELS(ANALOG_CHANNELS),
        .DIGITAL_INPUTS (DIGITAL_INPUTS),
        .COUNTED_INPUTS (COUNTED_INPUTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .avail       (avail),
        .pop         (pop),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_ren     (mem_ren),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .strobe      (strobe),
        .read_data   (read_data),
        .read_address(read_address),
        .burst_last  (burst_last)
    );

    io_exp_ram #(
        .WIDTH(8),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .ren  (mem_ren),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule

### hw/rtl/io_exp_checker.sv
`include "io_expander_register_map_top_macros.svh"

module io_exp_checker #(
    parameter int MAP_BYTES = io_exp_pkg::MAP_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [7:0] read_address,
    input logic       burst_last
);

    localparam logic [8:0] MAP_END = 9'(MAP_BYTES);

    // Every returned byte lies inside the map
    `IOX_ASSERT_NOW(a_addr_in_map, strobe, {1'b0, read_address} < MAP_END)

    // A burst streams consecutive addresses without gaps
    `IOX_ASSERT_NEXT(a_burst_step, strobe && !burst_last, strobe && (read_address == $past(read_address) + 8'd1))

    // The last beat of a burst is followed by an idle cycle
    `IOX_ASSERT_NEXT(a_burst_gap, strobe && burst_last, !strobe)

    // The final map byte always closes its burst
    `IOX_ASSERT_NOW(a_end_closes, strobe && ({1'b0, read_address} == MAP_END - 9'd1), burst_last)

endmodule

bind io_expander_register_map_top io_exp_checker #(
    .MAP_BYTES(MAP_BYTES)
) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .strobe      (strobe),
    .read_address(read_address),
    .burst_last  (burst_last)
);

### tb/sv/tb_io_expander_register_map_top.sv
module tb_io_expander_register_map_top;
    timeunit 1ns;
    timeprecision 1ps;
    import io_exp_pkg::*;

    localparam int MAP_SIZE   = 160;
    localparam int BURST_SIZE = 32;
    localparam int CNT_INPUTS = 2;

    // Mode codes with no function
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] bus_byte;
        logic [2:0] levels;
        logic [9:0] an0;
        logic [9:0] an1;
        logic [9:0] an2;
        logic [9:0] an3;
    } bus_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] addr;
        logic       last;
    } read_byte_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] mode;
    logic [7:0] bus_byte;
    logic [2:0] digital_levels;
    logic [9:0] analog_zero;
    logic [9:0] analog_one;
    logic [9:0] analog_two;
    logic [9:0] analog_three;
    logic       strobe;
    logic [7:0] read_data;
    logic [7:0] read_address;
    logic       burst_last;

    bus_cmd_t   pending_cmds[$];
    read_byte_t expected_bytes[$];
    bit         failed;
    bit         idle_allowed;
    int         send_gap;

    // shadow of the map and expander state
    logic [7:0]  shadow_map[MAP_SIZE];
    logic [7:0]  sh_pointer;
    logic [7:0]  sh_offset;
    bit          sh_writing;
    logic [1:0]  sh_prev;
    logic [31:0] sh_counts[CNT_INPUTS];
    int unsigned sh_poll;
    int unsigned sh_gate;

    io_expander_register_map_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .bus_byte(bus_byte), .digital_levels(digital_levels),
        .analog_zero(analog_zero), .analog_one(analog_one),
        .analog_two(analog_two), .analog_three(analog_three),
        .strobe(strobe), .read_data(read_data), .read_address(read_address),
        .burst_last(burst_last)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic shadow_reset();
        for (int a = 0; a < MAP_SIZE; a++)
        begin
            shadow_map[a] = 8'd0;
        end
        shadow_map[ADDR_ID]       = RST_ID;
        shadow_map[ADDR_HW]       = RST_VER;
        shadow_map[ADDR_FW]       = RST_VER;
        shadow_map[ADDR_POLL]     = RST_POLL;
        shadow_map[ADDR_DEBOUNCE] = RST_POLL;
        shadow_map[ADDR_GATE]     = RST_GATE;
        shadow_map[ADDR_EDGE]     = RST_EDGE;
        sh_pointer = '0;
        sh_offset  = '0;
        sh_writing = 0;
        sh_prev    = '0;
        sh_counts[0] = '0;
        sh_counts[1] = '0;
        sh_poll = 0;
        sh_gate = 0;
    endtask

    // advance the shadow by one accepted command, queue any read bytes
    task automatic expander_apply(input bus_cmd_t c);
        int unsigned p;
        int unsigned n;
        int unsigned a;
        bit          now_b;
        bit          was_b;
        bit          hit;
        logic [9:0]  an[4];
        case (c.mode)
            MODE_ADDR:
            begin
                if (c.bus_byte < MAP_SIZE)
                begin
                    sh_pointer = c.bus_byte;
                    sh_offset  = c.bus_byte;
                    sh_writing = 1;
                end
                else
                begin
                    sh_writing = 0;
                end
            end
            MODE_DATA:
            begin
                if (sh_writing && sh_offset < MAP_SIZE)
                begin
                    shadow_map[sh_offset] = c.bus_byte;
                    if (sh_offset + 1 >= MAP_SIZE)
                        sh_writing = 0;
                    else
                        sh_offset = sh_offset + 8'd1;
                end
                else
                begin
                    sh_writing = 0;
                end
            end
            MODE_READ:
            begin
                sh_writing = 0;
                p = sh_pointer;
                if (p >= MAP_SIZE)
                    p = 0;
                n = (p + BURST_SIZE > MAP_SIZE) ? MAP_SIZE - p : BURST_SIZE;
                for (int k = 0; k < n; k++)
                begin
                    expected_bytes.push_back('{shadow_map[p + k], 8'(p + k), k + 1 == n});
                end
            end
            MODE_SAMPLE:
            begin
                for (int i = 0; i < CNT_INPUTS; i++)
                begin
                    now_b = c.levels[i];
                    was_b = sh_prev[i];
                    hit = 0;
                    if (shadow_map[ADDR_EDGE] == EDGE_ANY)
                        hit = now_b != was_b;
                    else if (shadow_map[ADDR_EDGE] == EDGE_FALL)
                        hit = !now_b && was_b;
                    else if (shadow_map[ADDR_EDGE] == EDGE_RISE)
                        hit = now_b && !was_b;
                    if (hit)
                        sh_counts[i] = sh_counts[i] + 32'd1;
                    sh_prev[i] = now_b;
                end
            end
            MODE_TICK:
            begin
                sh_poll++;
                if (sh_poll > shadow_map[ADDR_POLL])
                begin
                    an = '{c.an0, c.an1, c.an2, c.an3};
                    for (int i = 0; i < 4; i++)
                    begin
                        shadow_map[BASE_ANALOG + 2 * i]     = {6'd0, an[i][9:8]};
                        shadow_map[BASE_ANALOG + 2 * i + 1] = an[i][7:0];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        shadow_map[BASE_DIGITAL + i] = {7'd0, c.levels[i]};
                    end
                    sh_poll = 0;
                end
                sh_gate++;
                if (sh_gate >= shadow_map[ADDR_GATE] * 1000)
                begin
                    for (int i = 0; i < CNT_INPUTS; i++)
                    begin
                        a = BASE_COUNT + 4 * i;
                        shadow_map[a]     = sh_counts[i][31:24];
                        shadow_map[a + 1] = sh_counts[i][23:16];
                        shadow_map[a + 2] = sh_counts[i][15:8];
                        shadow_map[a + 3] = sh_counts[i][7:0];
                        sh_counts[i] = '0;
                    end
                    sh_gate = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic bus_cmd_t make_cmd(input logic [2:0] m, input logic [7:0] b);
        bus_cmd_t c;
        c.mode     = m;
        c.bus_byte = b;
        c.levels   = 3'($urandom_range(0, 7));
        c.an0      = 10'($urandom_range(0, 1023));
        c.an1      = 10'($urandom_range(0, 1023));
        c.an2      = 10'($urandom_range(0, 1023));
        c.an3      = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    task automatic queue_write(input logic [7:0] addr, input int len);
        pending_cmds.push_back(make_cmd(MODE_ADDR, addr));
        for (int i = 0; i < len; i++)
        begin
            pending_cmds.push_back(make_cmd(MODE_DATA, 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic queue_ticks(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_cmds.push_back(make_cmd(MODE_TICK, 8'($urandom_range(0, 255))));
        end
    endtask

    // feed commands, with random gaps while idling is allowed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= '0;
            bus_byte <= '0;
            digital_levels <= '0;
            analog_zero <= '0;
            analog_one <= '0;
            analog_two <= '0;
            analog_three <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expander_apply(pending_cmds.pop_front());
            end
            if (start && busy)
            begin
                // hold the beat
            end
            else if (send_gap > 0)
            begin
                start <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cmds.size() > 0 && !(start && pending_cmds.size() == 0))
            begin
                start <= 1'b1;
                mode <= pending_cmds[0].mode;
                bus_byte <= pending_cmds[0].bus_byte;
                digital_levels <= pending_cmds[0].levels;
                analog_zero <= pending_cmds[0].an0;
                analog_one <= pending_cmds[0].an1;
                analog_two <= pending_cmds[0].an2;
                analog_three <= pending_cmds[0].an3;
                if (idle_allowed && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 9);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // check each read byte against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected read byte at address %0d", read_address);
                failed = 1;
            end
            else
            begin
                if (read_data !== expected_bytes[0].data)
                begin
                    $error("read_data expected %0h actual %0h", expected_bytes[0].data,
                           read_data);
                    failed = 1;
                end
                if (read_address !== expected_bytes[0].addr)
                begin
                    $error("read_address expected %0d actual %0d",
                           expected_bytes[0].addr, read_address);
                    failed = 1;
                end
                if (burst_last !== expected_bytes[0].last)
                begin
                    $error("burst_last expected %0b actual %0b", expected_bytes[0].last,
                           burst_last);
                    failed = 1;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    initial
    begin
        int   kind;
        logic [7:0] addr;
        failed = 0;
        idle_allowed = 1;
        shadow_reset();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, map end, dropped data, edge modes, poll, gate
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_DATA, 8'hFF));
        queue_write(8'd0, 0);
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
        queue_write(8'd158, 4);
        pending_cmds.push_back(make_cmd(MODE_ADDR, 8'd159));
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_ADDR, 8'd160));
        pending_cmds.push_back(make_cmd(MODE_DATA, 8'h55));
        pending_cmds.push_back(make_cmd(MODE_ADDR, 8'd255));
        pending_cmds.push_back(make_cmd(MODE_SPARE_HI, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_SPARE_LO, 8'd0));
        // gate zero and poll zero make every tick latch
        pending_cmds.push_back(make_cmd(MODE_ADDR, ADDR_POLL));
        pending_cmds.push_back(make_cmd(MODE_DATA, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_ADDR, ADDR_GATE));
        pending_cmds.push_back(make_cmd(MODE_DATA, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_DATA, EDGE_ANY));
        for (int i = 0; i < 4; i++)
        begin
            pending_cmds.push_back(make_cmd(MODE_SAMPLE, 8'd0));
        end
        queue_ticks(1);
        pending_cmds.push_back(make_cmd(MODE_ADDR, BASE_ANALOG));
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_ADDR, BASE_COUNT));
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));

        // random: write transactions, edge setup, samples, ticks, reads
        for (int i = 0; i < 45; i++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: queue_write(8'($urandom_range(0, 159)), $urandom_range(1, 4));
                2:
                begin
                    pending_cmds.push_back(make_cmd(MODE_ADDR, ADDR_EDGE));
                    pending_cmds.push_back(make_cmd(MODE_DATA, 8'($urandom_range(0, 5))));
                end
                3:
                begin
                    pending_cmds.push_back(make_cmd(MODE_ADDR, ADDR_POLL));
                    pending_cmds.push_back(make_cmd(MODE_DATA, 8'($urandom_range(0, 3))));
                end
                4, 5: pending_cmds.push_back(make_cmd(MODE_SAMPLE, 8'($urandom_range(0, 255))));
                6: queue_ticks($urandom_range(1, 3));
                7:
                begin
                    addr = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(128, 159))
                                                       : 8'($urandom_range(0, 159));
                    pending_cmds.push_back(make_cmd(MODE_ADDR, addr));
                    pending_cmds.push_back(make_cmd(MODE_READ, 8'($urandom_range(0, 255))));
                end
                8: pending_cmds.push_back(make_cmd(3'($urandom_range(0, 7)),
                                                   8'($urandom_range(0, 255))));
                default: pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
            endcase
        end
        // restore a one-second gate, so the last ticks keep counting
        pending_cmds.push_back(make_cmd(MODE_ADDR, ADDR_GATE));
        pending_cmds.push_back(make_cmd(MODE_DATA, 8'd1));
        queue_ticks(3);
        pending_cmds.push_back(make_cmd(MODE_ADDR, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));
        pending_cmds.push_back(make_cmd(MODE_ADDR, BASE_COUNT));
        pending_cmds.push_back(make_cmd(MODE_READ, 8'd0));

        wait (pending_cmds.size() < 40);
        idle_allowed = 0;
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_bytes.size() == 0);
        repeat (60) @(posedge clk);
        if (!failed && expected_bytes.size() == 0)
        begin
            $display("tb_io_expander_register_map_top OK");
        end
        else
        begin
            $display("tb_io_expander_register_map_top NOT OK");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_io_expander_register_map_top NOT OK");
        $finish;
    end
endmodule
